>>> rtl/xdec_pkg.sv
// shared types, codes and decode helpers for the 16-bit x86 instruction decoder
`default_nettype none

package xdec_pkg;

    // operation codes
    localparam logic [2:0] OPER_MOV   = 3'd0;
    localparam logic [2:0] OPER_ADD   = 3'd1;
    localparam logic [2:0] OPER_SUB   = 3'd2;
    localparam logic [2:0] OPER_CMP   = 3'd3;
    localparam logic [2:0] OPER_UNREC = 3'd4;

    // encoding form codes
    localparam logic [1:0] FORM_REG_RM = 2'd0;
    localparam logic [1:0] FORM_IMM_RM = 2'd1;
    localparam logic [1:0] FORM_IMM_AX = 2'd2;

    // opcode patterns
    localparam logic [5:0] MOV_RM_PREFIX = 6'b100010;
    localparam logic [5:0] IMM_RM_PREFIX = 6'b100000;
    localparam logic [7:0] ACC_MASK      = 8'b11000110;
    localparam logic [7:0] ACC_PATTERN   = 8'b00000100;

    // extension codes
    localparam logic [2:0] EXT_ADD = 3'b000;
    localparam logic [2:0] EXT_SUB = 3'b101;
    localparam logic [2:0] EXT_CMP = 3'b111;
    localparam logic [2:0] RM_DIRECT = 3'b110;

    // mod field codes
    localparam logic [1:0] MOD_NO_DISP = 2'd0;
    localparam logic [1:0] MOD_DISP8   = 2'd1;
    localparam logic [1:0] MOD_DISP16  = 2'd2;
    localparam logic [1:0] MOD_REG     = 2'd3;

    localparam int unsigned IMM_W  = 17;
    localparam int unsigned DISP_W = 16;
    localparam int unsigned OUT_DATA_W = 56;

    // assembled instruction bytes handed from front to back
    typedef struct packed {
        logic [7:0]        opcode;
        logic [7:0]        modrm;
        logic [DISP_W-1:0] disp;
        logic [IMM_W-1:0]  imm;
    } instr_rec_t;

    function automatic logic is_acc_form(input logic [7:0] op);
        return (op & ACC_MASK) == ACC_PATTERN;
    endfunction

    function automatic logic is_imm_form(input logic [7:0] op);
        return op[7:2] == IMM_RM_PREFIX;
    endfunction

    // number of displacement bytes after a modrm byte
    function automatic logic [1:0] disp_len(input logic [7:0] modrm);
        logic [1:0] len;
        len = 2'd0;
        unique case (modrm[7:6])
            MOD_NO_DISP: len = (modrm[2:0] == RM_DIRECT) ? 2'd2 : 2'd0;
            MOD_DISP8:   len = 2'd1;
            MOD_DISP16:  len = 2'd2;
            MOD_REG:     len = 2'd0;
            default:     len = 2'd0;
        endcase
        return len;
    endfunction

    // number of immediate bytes for an opcode
    function automatic logic [1:0] imm_len(input logic [7:0] op);
        logic [1:0] len;
        len = 2'd0;
        if (is_acc_form(op))
        begin
            len = op[0] ? 2'd2 : 2'd1;
        end
        else if (is_imm_form(op))
        begin
            len = (!op[0] || op[1]) ? 2'd1 : 2'd2;
        end
        return len;
    endfunction

    function automatic logic [2:0] oper_from_ext(input logic [2:0] ext);
        logic [2:0] oper;
        unique case (ext)
            EXT_ADD: oper = OPER_ADD;
            EXT_SUB: oper = OPER_SUB;
            EXT_CMP: oper = OPER_CMP;
            default: oper = OPER_UNREC;
        endcase
        return oper;
    endfunction

endpackage

`default_nettype wire

>>> rtl/xdec_front.sv
// byte assembler: tracks the byte position and collects one instruction record
`default_nettype none

module xdec_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                byte_valid,
    input  wire logic [7:0]          byte_data,
    input  wire logic                push_ready,
    output logic                     byte_ready,
    output logic                     push_valid,
    output xdec_pkg::instr_rec_t     push_rec
);
    import xdec_pkg::*;

    typedef enum logic [2:0] {
        ST_OPCODE  = 3'd0,
        ST_MODRM   = 3'd1,
        ST_DISP_LO = 3'd2,
        ST_DISP_HI = 3'd3,
        ST_IMM_LO  = 3'd4,
        ST_IMM_HI  = 3'd5
    } stage_t;

    stage_t            stage_reg, stage_next;
    logic [7:0]        opcode_reg, opcode_next;
    logic [7:0]        modrm_reg, modrm_next;
    logic [DISP_W-1:0] disp_reg, disp_next;
    logic [7:0]        imm_lo_reg, imm_lo_next;
    logic [IMM_W-1:0]  imm_value;
    logic              done;
    logic              take;

    assign byte_ready = push_ready;
    assign take       = byte_valid && push_ready;

    // next stage and stored bytes
    always_comb
    begin
        stage_next  = stage_reg;
        opcode_next = opcode_reg;
        modrm_next  = modrm_reg;
        disp_next   = disp_reg;
        imm_lo_next = imm_lo_reg;
        imm_value   = '0;
        done        = 1'b0;
        unique case (stage_reg)
            ST_MODRM:
            begin
                modrm_next = byte_data;
                if (disp_len(byte_data) != 2'd0)
                begin
                    stage_next = ST_DISP_LO;
                end
                else if (imm_len(opcode_reg) != 2'd0)
                begin
                    stage_next = ST_IMM_LO;
                end
                else
                begin
                    done = 1'b1;
                end
            end
            ST_DISP_LO:
            begin
                disp_next = {{8{byte_data[7]}}, byte_data};
                if (disp_len(modrm_reg) == 2'd2)
                begin
                    stage_next = ST_DISP_HI;
                end
                else if (imm_len(opcode_reg) != 2'd0)
                begin
                    stage_next = ST_IMM_LO;
                end
                else
                begin
                    done = 1'b1;
                end
            end
            ST_DISP_HI:
            begin
                disp_next = {byte_data, disp_reg[7:0]};
                if (imm_len(opcode_reg) != 2'd0)
                begin
                    stage_next = ST_IMM_LO;
                end
                else
                begin
                    done = 1'b1;
                end
            end
            ST_IMM_LO:
            begin
                imm_lo_next = byte_data;
                if (imm_len(opcode_reg) == 2'd2)
                begin
                    stage_next = ST_IMM_HI;
                end
                else
                begin
                    done = 1'b1;
                    if (is_imm_form(opcode_reg) && opcode_reg[1] && opcode_reg[0]
                        && byte_data[7])
                    begin
                        imm_value = {9'h1FF, byte_data};
                    end
                    else
                    begin
                        imm_value = {9'h000, byte_data};
                    end
                end
            end
            ST_IMM_HI:
            begin
                done      = 1'b1;
                imm_value = {1'b0, byte_data, imm_lo_reg};
            end
            default:
            begin
                opcode_next = byte_data;
                modrm_next  = '0;
                disp_next   = '0;
                imm_lo_next = '0;
                stage_next  = is_acc_form(byte_data) ? ST_IMM_LO : ST_MODRM;
            end
        endcase
        if (done)
        begin
            stage_next = ST_OPCODE;
        end
    end

    // record handed to the queue on the completing byte
    assign push_valid      = take && done;
    assign push_rec.opcode = opcode_reg;
    assign push_rec.modrm  = modrm_next;
    assign push_rec.disp   = disp_next;
    assign push_rec.imm    = imm_value;

    // stage and byte stores
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg  <= ST_OPCODE;
            opcode_reg <= '0;
            modrm_reg  <= '0;
            disp_reg   <= '0;
            imm_lo_reg <= '0;
        end
        else if (take)
        begin
            stage_reg  <= stage_next;
            opcode_reg <= opcode_next;
            modrm_reg  <= modrm_next;
            disp_reg   <= disp_next;
            imm_lo_reg <= imm_lo_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/xdec_queue.sv
// two-entry queue of assembled instruction records
`default_nettype none

module xdec_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push_valid,
    input  wire xdec_pkg::instr_rec_t push_rec,
    output logic                     push_ready,
    output logic                     pop_valid,
    input  wire logic                pop_ready,
    output xdec_pkg::instr_rec_t     pop_rec
);
    import xdec_pkg::*;

    instr_rec_t  entry_reg [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  count_reg, count_next;
    logic        do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_rec    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // occupancy update
    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

`default_nettype wire

>>> rtl/xdec_back.sv
// field decode of an instruction record into the registered output transfer
`default_nettype none

module xdec_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          rec_valid,
    input  wire xdec_pkg::instr_rec_t          rec,
    output logic                               rec_ready,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [xdec_pkg::OUT_DATA_W-1:0]    out_data
);
    import xdec_pkg::*;

    logic              acc, immf;
    logic [2:0]        oper;
    logic [1:0]        form;
    logic [1:0]        mode;
    logic [2:0]        reg_f, rm_f;
    logic              direct;
    logic [DISP_W-1:0] disp;
    logic [OUT_DATA_W-1:0] data_next;
    logic              out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic              load;

    // field decode
    always_comb
    begin
        acc   = is_acc_form(rec.opcode);
        immf  = is_imm_form(rec.opcode);
        mode  = acc ? 2'd0 : rec.modrm[7:6];
        reg_f = acc ? 3'd0 : rec.modrm[5:3];
        rm_f  = acc ? 3'd0 : rec.modrm[2:0];
        if (rec.opcode[7:2] == MOV_RM_PREFIX)
        begin
            oper = OPER_MOV;
        end
        else if (immf)
        begin
            oper = oper_from_ext(reg_f);
        end
        else if (rec.opcode[7:6] == 2'b00)
        begin
            oper = oper_from_ext(rec.opcode[5:3]);
        end
        else
        begin
            oper = OPER_UNREC;
        end
        form   = acc ? FORM_IMM_AX : (immf ? FORM_IMM_RM : FORM_REG_RM);
        direct = !acc && (mode == MOD_NO_DISP) && (rm_f == RM_DIRECT);
        disp   = (acc || disp_len(rec.modrm) == 2'd0) ? '0 : rec.disp;
        data_next = {7'd0, rec.imm, disp, direct, rm_f, reg_f, mode,
                     rec.opcode[0], rec.opcode[1], form, oper};
    end

    assign load      = rec_valid && (!out_valid_reg || out_ready);
    assign rec_ready = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            out_valid_reg <= rec_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/x86_16bit_instruction_decoder.sv
// Byte-serial decoder for a subset of 16-bit x86 code (MOV and ADD/SUB/CMP register/memory,
// immediate and accumulator forms). One code byte is taken per cycle with no gaps between
// instructions while the queue has room; the byte that completes an instruction
// produces one decoded record, which the front assembler pushes into a two-record
// queue and the back decoder decodes into an output register, so an output stall holds
// off input bytes only once the queue is full. The byte assembler sets that rate.
`default_nettype none

module x86_16bit_instruction_decoder (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // code_byte[7:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // operation[2:0], encoding_form[4:3], direction_bit[5], wide_bit[6], mode_field[8:7],
    // reg_field[11:9], rm_field[14:12], direct_flag[15], displacement[31:16],
    // immediate[48:32], zero[55:49]
    output logic [xdec_pkg::OUT_DATA_W-1:0] m_tdata
);
    import xdec_pkg::*;

    instr_rec_t push_rec, pop_rec;
    logic       push_valid, push_ready;
    logic       pop_valid, pop_ready;

    // byte assembly
    xdec_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (s_tvalid),
        .byte_data  (s_tdata),
        .push_ready (push_ready),
        .byte_ready (s_tready),
        .push_valid (push_valid),
        .push_rec   (push_rec)
    );

    // record queue
    xdec_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_rec   (push_rec),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_rec    (pop_rec)
    );

    // field decode and output
    xdec_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec_valid (pop_valid),
        .rec       (pop_rec),
        .rec_ready (pop_ready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

`default_nettype wire
